// ===== sv/gpa_pkg.sv =====
`timescale 1ns / 1ps
package gpa_pkg;
   localparam int WordBits = 32;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_NONE_FREE = 3'd1,
      ST_BELOW     = 3'd2,
      ST_BEYOND    = 3'd3,
      ST_NOT_ALLOC = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      CSR_FIRST_ID = 2'd0,
      CSR_EPP      = 2'd1,
      CSR_POOLS    = 2'd2,
      CSR_BYTES    = 2'd3
   } csr_idx_type;

   typedef enum logic [3:0] {
      S_IDLE, S_CLEAR, S_SCAN, S_SCAN_WAIT, S_CHECK, S_DIV, S_POOL_RD, S_POOL_WAIT,
      S_MUL, S_WRITE, S_SHRINK_RD, S_SHRINK_WAIT, S_RESP
   } state_type;

   // packed MSB first: status ends up in the lowest bits
   typedef struct packed {
      logic [3:0]  pools_live;
      logic        pool_added;
      logic [29:0] byte_offset;
      logic [2:0]  pool_number;
      logic [31:0] granted_id;
      logic [2:0]  status;
   } rsp_type;
endpackage

// ===== sv/gpa_divider.sv =====
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
module gpa_divider import gpa_pkg::*; #(
   parameter int NBits = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NBits-1:0] dividend,
   input  logic [10:0]      divisor,
   output logic             done,
   output logic [NBits-1:0] quotient,
   output logic [NBits-1:0] remainder
);
   localparam int CntW = $clog2(NBits + 1);
   logic [NBits-1:0] q_ff, q_in;
   logic [NBits:0]   r_ff, r_in;
   logic [CntW-1:0]  cnt_ff, cnt_in;
   logic             busy_ff, busy_in, done_ff, done_in;
   logic [NBits:0]   trial;

   always_comb begin
      q_in = q_ff;
      r_in = r_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial = {r_ff[NBits-1:0], q_ff[NBits-1]};
      if (start) begin
         q_in = dividend;
         r_in = '0;
         cnt_in = CntW'(NBits);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= (NBits+1)'(divisor)) begin
            r_in = trial - (NBits+1)'(divisor);
            q_in = {q_ff[NBits-2:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[NBits-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      r_ff <= r_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quotient = q_ff;
   assign remainder = r_ff[NBits-1:0];
endmodule

// ===== sv/growing_pool_id_allocator.sv =====
`timescale 1ns / 1ps
// Channel  | dir | handshake          | payload
// req      | in  | req_tvalid/tready  | tuser: req_type; tdata: release_id
// rsp      | out | rsp_tvalid/tready  | tdata: status,granted_id,pool_number,byte_offset,
//          |     |                    |        pool_added,pools_live
// csr      | in  | csr_valid/ready    | csr_index, csr_wdata
//
// One transaction at a time. Allocate scans the free bitmap one 32-bit word at a
// time (S_SCAN, S_SCAN_WAIT); release checks the id and reads its bitmap word. Both
// then run a bit-serial divide by pool size, counter update (allocate may add a pool)
// and, on free, a shrink walk of the pools from the last live one downward.
// After reset a clearing pass sets every bitmap word to all free.
// The result register holds while rsp_tready is low; no new request is taken then.
module growing_pool_id_allocator import gpa_pkg::*; #(
   parameter int MaxEntities = 1024,
   parameter int MaxPools    = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // release_id
   input  logic        req_tuser,  // req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,  // status[2:0], granted_id[34:3], pool_number[37:35],
                                   // byte_offset[67:38], pool_added[68], pools_live[72:69]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   localparam int Words = (MaxEntities + WordBits - 1) / WordBits;
   localparam int WAw   = (Words > 1) ? $clog2(Words) : 1;
   localparam int IdxW  = $clog2(MaxEntities + 1) + 1;
   localparam int PW    = (MaxPools > 1) ? $clog2(MaxPools) : 1;
   localparam int PCW   = $clog2(MaxPools + 1);

   // configuration
   logic [31:0] first_id_ff;
   logic [10:0] epp_ff;
   logic [3:0]  pcnt_ff;
   logic [20:0] ebytes_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_id_ff <= '0;
         epp_ff <= 11'd128;
         pcnt_ff <= 4'd8;
         ebytes_ff <= 21'd64;
      end else if (csr_valid) begin
         unique case (csr_idx_type'(csr_index))
            CSR_FIRST_ID: first_id_ff <= csr_wdata;
            CSR_EPP:      epp_ff <= csr_wdata[10:0];
            CSR_POOLS:    pcnt_ff <= csr_wdata[3:0];
            CSR_BYTES:    ebytes_ff <= csr_wdata[20:0];
            default: ;
         endcase
      end
   end
   assign csr_ready = 1'b1;

   // effective values; total and threshold are registered while idle and held during a transaction
   logic [10:0]    epp_eff;
   logic [PCW-1:0] pools_eff;
   logic [IdxW-1:0] total_ff;
   logic [10:0]    thr_ff;
   logic [16:0]    tot_prod;
   logic [13:0]    thr_prod;
   assign epp_eff = (epp_ff == '0) ? 11'd1 : epp_ff;
   assign pools_eff = (pcnt_ff == '0) ? PCW'(1) :
                      ({28'd0, pcnt_ff} > MaxPools) ? PCW'(MaxPools) : PCW'(pcnt_ff);
   assign tot_prod = 17'(epp_eff) * 17'(pools_eff);
   // x*4/5 via multiply by reciprocal: floor(x*4*13108 >> 16) exact for x < 2048
   assign thr_prod = 14'({epp_eff, 2'b00});

   // bitmap memory, one word per entry
   logic [WordBits-1:0] bmap [Words];
   logic [WAw-1:0]      bm_raddr, bm_waddr;
   logic                bm_we;
   logic [WordBits-1:0] bm_wdata, bm_rdata_ff;
   always_ff @(posedge clock) begin
      if (bm_we) bmap[bm_waddr] <= bm_wdata;
      bm_rdata_ff <= bmap[bm_raddr];
   end

   // pool counter memory
   logic [10:0]  pmem [MaxPools];
   logic [PW-1:0] pm_raddr, pm_waddr;
   logic          pm_we;
   logic [10:0]   pm_wdata, pm_rdata_ff;
   always_ff @(posedge clock) begin
      if (pm_we) pmem[pm_waddr] <= pm_wdata;
      pm_rdata_ff <= pmem[pm_raddr];
   end
   // counter memory reset value comes from a valid bit per pool
   logic [MaxPools-1:0] pvalid_ff;
   logic                pvalid_rd_ff;
   logic [10:0]         pool_val;
   assign pool_val = pvalid_rd_ff ? pm_rdata_ff : 11'd0;

   // control registers
   state_type      state_ff, state_in;
   logic [WAw:0]   waddr_ff;
   logic           op_ff;
   logic [31:0]    id_ff;
   logic [IdxW-1:0] idx_ff;
   logic [WordBits-1:0] word_ff;
   logic [PW-1:0]  pool_ff;
   logic [10:0]    rem_ff;
   logic [4:0]     pcr_ff;
   logic           added_ff;
   logic [2:0]     status_ff;
   logic           rsp_valid_ff;
   logic [10:0]    last_used_ff;
   logic [16:0]    thr_mul;
   rsp_type        rsp_ff;

   assign thr_mul = 17'(thr_prod);

   // divider
   logic             div_start, div_done;
   logic [IdxW-1:0]  div_q, div_r;
   logic [IdxW-1:0]  div_dividend;
   gpa_divider #(.NBits(IdxW)) u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(div_dividend), .divisor(epp_eff),
      .done(div_done), .quotient(div_q), .remainder(div_r)
   );

   // lowest set bit of fetched word
   logic [4:0] low_bit;
   logic       word_any;
   always_comb begin
      low_bit = '0;
      for (int b = WordBits - 1; b >= 0; b--) begin
         if (bm_rdata_ff[b]) low_bit = 5'(b);
      end
   end
   assign word_any = (bm_rdata_ff != '0);

   logic [IdxW-1:0] cand_idx;
   assign cand_idx = IdxW'({waddr_ff[WAw-1:0], low_bit});
   // allocate starts the divide in the same cycle the candidate is found
   assign div_dividend = (state_ff == S_SCAN_WAIT) ? cand_idx : idx_ff;
   logic [32:0] id_diff;
   assign id_diff = {1'b0, id_ff} - {1'b0, first_id_ff};
   logic [50:0] off_prod;
   logic [29:0] off_ff;
   assign off_prod = 51'(rem_ff) * 51'(ebytes_ff);
   logic shrink_go;
   logic [PW-1:0] pool_sel;
   assign pool_sel = (div_q >= IdxW'(MaxPools)) ? PW'(MaxPools - 1) : PW'(div_q);

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE)
         total_ff <= (tot_prod > 17'(MaxEntities)) ? IdxW'(MaxEntities) : IdxW'(tot_prod);
      if (state_ff == S_IDLE)
         thr_ff <= 11'((32'(thr_mul) * 32'd13108) >> 16);
   end

   // shrink walk: stage 0 holds the last pool's count, stage 1 sees the one before it
   logic shr_stage_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR:  if (waddr_ff == (WAw+1)'(Words - 1)) state_in = S_IDLE;
         S_IDLE:   if (req_tvalid && !rsp_valid_ff) state_in = req_tuser ? S_CHECK : S_SCAN;
         S_SCAN:   state_in = S_SCAN_WAIT;
         S_SCAN_WAIT: begin
            if (word_any && cand_idx < total_ff) state_in = S_DIV;
            else if (word_any || (((WAw+1)'(1) + waddr_ff) * WordBits >= total_ff))
               state_in = S_RESP;
            else state_in = S_SCAN;
         end
         S_CHECK: begin
            if (id_diff[32] || id_diff[31:0] >= 32'(total_ff)) state_in = S_RESP;
            else state_in = S_POOL_RD;
         end
         S_POOL_RD:   state_in = S_POOL_WAIT;
         S_POOL_WAIT: begin
            if (bm_rdata_ff[idx_ff[4:0]]) state_in = S_RESP;
            else state_in = S_DIV;
         end
         S_DIV:    if (div_done) state_in = S_MUL;
         S_MUL:    state_in = S_WRITE;
         S_WRITE:  state_in = op_ff ? S_SHRINK_RD : S_RESP;
         S_SHRINK_RD:   state_in = shrink_go ? S_SHRINK_WAIT : S_RESP;
         S_SHRINK_WAIT: begin
            if (shr_stage_ff)
               state_in = (last_used_ff != '0 || pool_val > thr_ff) ? S_RESP : S_SHRINK_RD;
         end
         S_RESP:   state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // pool counter read address
   logic [PW-1:0] shr_rd;
   assign shrink_go = (pcr_ff > 5'd1) && (pcr_ff <= 5'(MaxPools)) && (pcr_ff[0] | 1'b1);
   assign shr_rd = PW'(pcr_ff - 5'd2);

   // outputs and datapath (combinational block for the sequencer's memory and divider controls)
   always_comb begin
      bm_raddr = waddr_ff[WAw-1:0];
      bm_we = 1'b0;
      bm_waddr = idx_ff[WAw+4:5];
      bm_wdata = word_ff;
      pm_raddr = pool_ff;
      pm_we = 1'b0;
      pm_waddr = pool_ff;
      pm_wdata = '0;
      div_start = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            bm_we = 1'b1;
            bm_waddr = waddr_ff[WAw-1:0];
            bm_wdata = '1;
         end
         S_POOL_RD: bm_raddr = idx_ff[WAw+4:5];
         S_DIV: if (div_done) pm_raddr = pool_sel;
         S_MUL: begin
            bm_we = 1'b1;
            bm_wdata = word_ff;
            bm_wdata[idx_ff[4:0]] = op_ff;
            pm_we = 1'b1;
            pm_wdata = op_ff ? ((pool_val != '0) ? pool_val - 1'b1 : pool_val)
                             : pool_val + 1'b1;
         end
         S_SHRINK_RD: pm_raddr = PW'(pcr_ff - 5'd1);
         S_SHRINK_WAIT: pm_raddr = shr_rd;
         default: ;
      endcase
      if ((state_ff == S_SCAN_WAIT && state_in == S_DIV) ||
          (state_ff == S_POOL_WAIT && state_in == S_DIV))
         div_start = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         waddr_ff <= '0;
         rsp_valid_ff <= 1'b0;
         pvalid_ff <= '0;
         pcr_ff <= 5'd1;
         shr_stage_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pvalid_rd_ff <= pvalid_ff[pm_raddr];
         if (pm_we) pvalid_ff[pm_waddr] <= 1'b1;
         if (rsp_valid_ff && rsp_tready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_CLEAR: waddr_ff <= waddr_ff + 1'b1;
            S_IDLE: begin
               waddr_ff <= '0;
               op_ff <= req_tuser;
               id_ff <= req_tdata;
               added_ff <= 1'b0;
               status_ff <= ST_OK;
            end
            S_SCAN_WAIT: begin
               word_ff <= bm_rdata_ff;
               idx_ff <= cand_idx;
               if (!(word_any && cand_idx < total_ff)) begin
                  waddr_ff <= waddr_ff + 1'b1;
                  if (state_in == S_RESP) status_ff <= ST_NONE_FREE;
               end
            end
            S_CHECK: begin
               idx_ff <= IdxW'(id_diff[31:0]);
               if (id_diff[32]) status_ff <= ST_BELOW;
               else if (id_diff[31:0] >= 32'(total_ff)) status_ff <= ST_BEYOND;
            end
            S_POOL_WAIT: begin
               word_ff <= bm_rdata_ff;
               if (!bm_rdata_ff[idx_ff[4:0]]) status_ff <= ST_OK;
               if (bm_rdata_ff[idx_ff[4:0]]) status_ff <= ST_NOT_ALLOC;
            end
            S_DIV: if (div_done) begin
               pool_ff <= pool_sel;
               rem_ff <= 11'(div_r);
            end
            S_MUL: begin
               off_ff <= off_prod[29:0];
               if (!op_ff && ({1'b0, pcr_ff} < 6'(pools_eff)) &&
                   (5'(pool_ff) + 5'd1 >= pcr_ff) && (pool_val > thr_ff)) begin
                  pcr_ff <= pcr_ff + 1'b1;
                  added_ff <= 1'b1;
               end
            end
            S_SHRINK_WAIT: begin
               if (!shr_stage_ff) begin
                  last_used_ff <= pool_val;
                  shr_stage_ff <= 1'b1;
               end else begin
                  shr_stage_ff <= 1'b0;
                  if (state_in == S_SHRINK_RD) pcr_ff <= pcr_ff - 1'b1;
               end
            end
            S_SHRINK_RD: begin
               shr_stage_ff <= 1'b0;
            end
            S_RESP: begin
               rsp_valid_ff <= 1'b1;
               rsp_ff.status <= status_ff;
               rsp_ff.granted_id <= (status_ff == ST_OK && !op_ff) ?
                                    32'(idx_ff) + first_id_ff : '0;
               rsp_ff.pool_number <= (status_ff == ST_OK) ? 3'(pool_ff) : '0;
               rsp_ff.byte_offset <= (status_ff == ST_OK) ? off_ff : '0;
               rsp_ff.pool_added <= added_ff;
               rsp_ff.pools_live <= 4'(pcr_ff);
            end
            default: ;
         endcase
      end
   end

   assign req_tready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_ff};
endmodule

// ===== sv/gpa_checker.sv =====
`timescale 1ns / 1ps
module gpa_checker import gpa_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [79:0] rsp_tdata
);
   ap_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata)) else $error("rsp changed");
   ap_noreq: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("req taken while rsp pending");
   ap_err: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2:0] != ST_OK |-> rsp_tdata[34:3] == '0)
      else $error("id on error");
   ap_live: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[72:69] != 4'd0) else $error("no pools");
endmodule

bind growing_pool_id_allocator gpa_checker u_gpa_checker (.*);
